[rtl/nst_pkg.sv]
// Shared types and codes of the node slot table.
`default_nettype none

package nst_pkg;

	// Command codes carried by an input item
	typedef enum logic [2:0] {
		CMD_ALLOCATE   = 3'd0,
		CMD_NEXT       = 3'd1,
		CMD_FIND_ALIAS = 3'd2,
		CMD_FIND_ID    = 3'd3,
		CMD_TICK       = 3'd4,
		CMD_SET_ALIAS  = 3'd5
	} cmd_t;

	// Sequencer states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} state_t;

	// Field widths fixed by the item format
	localparam int unsigned ID_W    = 64;
	localparam int unsigned ALIAS_W = 12;
	localparam int unsigned TICKS_W = 16;

	// One stored slot
	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [ALIAS_W-1:0] alias_val;
		logic [TICKS_W-1:0] ticks;
	} entry_t;

endpackage

`default_nettype wire

[rtl/nst_if.sv]
// Request and response channel interfaces of the node slot table.
`default_nettype none

interface nst_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [63:0] node_id;
	logic [11:0] alias_in;
	logic [2:0]  slot_in;

	modport source (output valid, command, node_id, alias_in, slot_in, input ready);
	modport sink (input valid, command, node_id, alias_in, slot_in, output ready);
endinterface

interface nst_rsp_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [2:0]  slot_out;
	logic [63:0] id_out;
	logic [11:0] alias_out;
	logic [15:0] ticks_out;
	logic [3:0]  active_count;
	logic [15:0] send_timeout;

	modport source (output valid, found, slot_out, id_out, alias_out, ticks_out,
		active_count, send_timeout, input ready);
	modport sink (input valid, found, slot_out, id_out, alias_out, ticks_out,
		active_count, send_timeout, output ready);
endinterface

`default_nettype wire

[rtl/node_slot_table.sv]
// Node slot table: allocate, round-robin, lookup, tick and alias write over a slot memory.
//
// The table holds SLOT_COUNT slots in one synchronous memory (one write and one
// read port, registered read). Slots fill in order and are never freed, so
// slots 0 to count-1 are active. One item is worked at a time: allocate, unused
// commands, and next active or set alias that return no slot load a result
// without a memory read, next active and set alias that return a slot first
// read that slot, and find alias, find id and tick scan the active slots, since
// the single read port visits one active slot per cycle. A new item is accepted
// the cycle after the result is loaded into the output register, even while
// that result still waits to be taken. Memory contents are not cleared at
// reset; only active slots are ever read.
`default_nettype none

module node_slot_table #(
	parameter int unsigned SLOT_COUNT = 8
) (
	input wire logic  clk,
	input wire logic  arst_n,
	nst_req_if.sink   req,
	nst_rsp_if.source rsp
);

	localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int unsigned CW = $clog2(SLOT_COUNT + 1);
	localparam int unsigned XW = CW + 3;

	// Slot memory
	nst_pkg::entry_t mem [SLOT_COUNT];

	// Control state
	nst_pkg::state_t state_q, state_d;
	nst_pkg::cmd_t   cmd_q;
	logic [CW-1:0]   count_q;
	logic [SW-1:0]   rr_q;
	logic [15:0]     timeout_q;
	logic [CW-1:0]   rem_q;
	logic [SW-1:0]   addr_q;
	logic            rv_s1;
	logic            rsp_valid_q;

	// Latched item payload
	logic [63:0] id_q;
	logic [11:0] alias_q;

	// Read stage
	nst_pkg::entry_t rd_data_s1;
	logic [SW-1:0]   ridx_s1;

	// Output register payload
	logic        found_q;
	logic [2:0]  slot_out_q;
	logic [63:0] id_out_q;
	logic [11:0] alias_out_q;
	logic [15:0] ticks_out_q;
	logic [3:0]  count_out_q;
	logic [15:0] timeout_out_q;

	// Combinational control
	logic            accept;
	logic            hit;
	logic            fin;
	logic            done;
	logic            out_free;
	logic            alloc_ok;
	logic            rd_en;
	logic            wr_en;
	logic [SW-1:0]   wr_addr;
	nst_pkg::entry_t wr_data;
	logic            res_found;
	logic [2:0]      res_slot;
	logic [63:0]     res_id;
	logic [11:0]     res_alias;
	logic [15:0]     res_ticks;
	logic [CW-1:0]   count_nx;
	logic [15:0]     timeout_nx;
	logic [SW-1:0]   rr_nx;
	logic [CW:0]     rr_inc;
	logic            slot_ok;
	logic [CW-1:0]   rem_init;
	logic [SW-1:0]   addr_init;
	nst_pkg::cmd_t   cmd_in;

	assign cmd_in   = nst_pkg::cmd_t'(req.command);
	assign out_free = !rsp_valid_q || rsp.ready;
	assign accept   = req.valid && req.ready;
	assign slot_ok  = XW'(req.slot_in) < XW'(count_q);
	assign rr_inc   = (CW + 1)'(rr_q) + (CW + 1)'(1);

	// Decide scan length and start address of a new item
	always_comb begin
		rem_init  = '0;
		addr_init = '0;
		case (cmd_in)
			nst_pkg::CMD_NEXT: begin
				addr_init = rr_q;
				rem_init  = (count_q != '0) ? CW'(1) : '0;
			end
			nst_pkg::CMD_FIND_ALIAS, nst_pkg::CMD_FIND_ID, nst_pkg::CMD_TICK: begin
				rem_init = count_q;
			end
			nst_pkg::CMD_SET_ALIAS: begin
				addr_init = SW'(req.slot_in);
				rem_init  = slot_ok ? CW'(1) : '0;
			end
			default: begin
				rem_init = '0;
			end
		endcase
	end

	// Sequence the item: issue reads, compare, write back, finish
	always_comb begin
		state_d   = state_q;
		req.ready = (state_q == nst_pkg::ST_IDLE);
		hit       = 1'b0;
		case (cmd_q)
			nst_pkg::CMD_NEXT, nst_pkg::CMD_SET_ALIAS: hit = 1'b1;
			nst_pkg::CMD_FIND_ALIAS: hit = (rd_data_s1.alias_val == alias_q);
			nst_pkg::CMD_FIND_ID:    hit = (rd_data_s1.id == id_q);
			default:                 hit = 1'b0;
		endcase

		alloc_ok = (cmd_q == nst_pkg::CMD_ALLOCATE) && (count_q < CW'(SLOT_COUNT));
		fin      = (state_q == nst_pkg::ST_RUN)
			&& ((rv_s1 && hit) || (rem_q == '0 && !rv_s1));
		done     = fin && out_free;
		rd_en    = (state_q == nst_pkg::ST_RUN) && !fin && (rem_q != '0);

		// Result of the finishing item
		res_found = (rv_s1 && hit) || alloc_ok;
		res_slot  = '0;
		res_id    = '0;
		res_alias = '0;
		res_ticks = '0;
		if (alloc_ok) begin
			res_slot = 3'(SW'(count_q));
			res_id   = id_q;
		end else if (rv_s1 && hit) begin
			res_slot  = 3'(ridx_s1);
			res_id    = rd_data_s1.id;
			res_alias = (cmd_q == nst_pkg::CMD_SET_ALIAS) ? alias_q : rd_data_s1.alias_val;
			res_ticks = rd_data_s1.ticks;
		end

		count_nx   = alloc_ok ? count_q + CW'(1) : count_q;
		timeout_nx = (cmd_q == nst_pkg::CMD_TICK) ? timeout_q + 16'd1 : timeout_q;
		rr_nx      = (rr_inc >= (CW + 1)'(count_q)) ? '0 : SW'(rr_inc);

		// Write back: tick per visited slot, alias or new slot on finish
		wr_en   = 1'b0;
		wr_addr = ridx_s1;
		wr_data = rd_data_s1;
		if (state_q == nst_pkg::ST_RUN) begin
			if (cmd_q == nst_pkg::CMD_TICK && rv_s1) begin
				wr_en         = 1'b1;
				wr_data.ticks = rd_data_s1.ticks + 16'd1;
			end else if (cmd_q == nst_pkg::CMD_SET_ALIAS && rv_s1 && done) begin
				wr_en             = 1'b1;
				wr_data.alias_val = alias_q;
			end else if (alloc_ok && done) begin
				wr_en     = 1'b1;
				wr_addr   = SW'(count_q);
				wr_data   = '{id: id_q, alias_val: '0, ticks: '0};
			end
		end

		case (state_q)
			nst_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = nst_pkg::ST_RUN;
				end
			end
			nst_pkg::ST_RUN: begin
				if (done) begin
					state_d = nst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nst_pkg::ST_IDLE;
			end
		endcase
	end

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nst_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q       <= nst_pkg::CMD_ALLOCATE;
			count_q     <= '0;
			rr_q        <= '0;
			timeout_q   <= '0;
			rem_q       <= '0;
			addr_q      <= '0;
			rv_s1       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// Raise valid on a loaded result, drop it once the item is taken
			if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (accept) begin
				cmd_q  <= cmd_in;
				rem_q  <= rem_init;
				addr_q <= addr_init;
				rv_s1  <= 1'b0;
			end else if (done) begin
				rv_s1       <= 1'b0;
				count_q     <= count_nx;
				timeout_q   <= timeout_nx;
				if (cmd_q == nst_pkg::CMD_NEXT && rv_s1) begin
					rr_q <= rr_nx;
				end
			end else if (state_q == nst_pkg::ST_RUN && !fin) begin
				rv_s1 <= rd_en;
				if (rd_en) begin
					rem_q  <= rem_q - CW'(1);
					addr_q <= addr_q + SW'(1);
				end
			end
		end
	end

	// Latch the item payload and load the output register
	always_ff @(posedge clk) begin
		if (accept) begin
			id_q    <= req.node_id;
			alias_q <= req.alias_in;
		end
		if (done) begin
			found_q       <= res_found;
			slot_out_q    <= res_slot;
			id_out_q      <= res_id;
			alias_out_q   <= res_alias;
			ticks_out_q   <= res_ticks;
			count_out_q   <= 4'(count_nx);
			timeout_out_q <= timeout_nx;
		end
	end

	// Slot memory: one write and one registered read per cycle, never the same
	// entry in one cycle, so no forwarding is needed
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[addr_q];
			ridx_s1    <= addr_q;
		end
	end

	// Drive the response channel
	assign rsp.valid        = rsp_valid_q;
	assign rsp.found        = found_q;
	assign rsp.slot_out     = slot_out_q;
	assign rsp.id_out       = id_out_q;
	assign rsp.alias_out    = alias_out_q;
	assign rsp.ticks_out    = ticks_out_q;
	assign rsp.active_count = count_out_q;
	assign rsp.send_timeout = timeout_out_q;

endmodule

`default_nettype wire
